### hdl/ltgp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LZSS token group packer.
// No dependencies; imported by ltgp_ctrl, ltgp_datapath and lzss_token_group_packer.
package ltgp_pkg;

    localparam int GROUP_TOKENS = 16;
    localparam int FREE_W       = 5;    // holds 0..GROUP_TOKENS
    localparam int SLOT_W       = 4;    // indexes one group slot

    localparam logic [1:0] KIND_LIT   = 2'd0;
    localparam logic [1:0] KIND_MATCH = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_DESC_HI,
        ST_DESC_LO,
        ST_PAY_HI,
        ST_PAY_LO
    } state_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_DESC_HI,
        SEL_DESC_LO,
        SEL_PAY_HI,
        SEL_PAY_LO
    } sel_t;

    typedef struct packed {
        logic load_in;
        logic put;
        logic idx_clear;
        sel_t emit_sel;
        logic emit_last;
        logic emit_eos;
        logic clear_group;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic out_free;
        logic group_empty;
        logic pay_done;
    } sts_t;

endpackage

### hdl/ltgp_datapath.sv
`timescale 1ns / 1ps
// Datapath: token word build, descriptor/free-slot registers, group payload memory
// and the byte output register. Depends on ltgp_pkg; driven by ltgp_ctrl.
module ltgp_datapath
    import ltgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [1:0]  kind,
    input  logic [15:0] literal_word,
    input  logic [8:0]  distance,
    input  logic [8:0]  match_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        end_of_stream
);

    logic [15:0]       word_reg;
    logic              bit_reg;
    logic [15:0]       desc_reg, desc_next;
    logic [FREE_W-1:0] free_reg, free_next;
    logic [FREE_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       rd_reg;
    logic [7:0]        lo_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_eos_reg;
    logic [15:0]       mem [GROUP_TOKENS];

    logic [FREE_W-1:0] used;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       desc_wide;
    logic [15:0]       desc_aligned;
    logic [7:0]        emit_byte;
    logic              emit;

    assign used         = FREE_W'(GROUP_TOKENS) - free_reg;
    assign slot         = used[SLOT_W-1:0];
    assign desc_wide    = {16'd0, desc_reg} << free_reg;
    assign desc_aligned = desc_wide[15:0];
    assign emit         = (cmd.emit_sel != SEL_NONE);

    assign sts.full        = (free_reg == '0);
    assign sts.out_free    = !out_valid_reg || out_ready;
    assign sts.group_empty = (used == '0);
    assign sts.pay_done    = (idx_reg == used);

    always_comb
    begin
        case (cmd.emit_sel)
            SEL_DESC_HI: emit_byte = desc_aligned[15:8];
            SEL_DESC_LO: emit_byte = desc_aligned[7:0];
            SEL_PAY_HI:  emit_byte = rd_reg[15:8];
            SEL_PAY_LO:  emit_byte = lo_reg;
            default:     emit_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        desc_next = desc_reg;
        free_next = free_reg;
        if (cmd.clear_group)
        begin
            desc_next = '0;
            free_next = FREE_W'(GROUP_TOKENS);
        end
        else if (cmd.put)
        begin
            desc_next = {desc_reg[14:0], bit_reg};
            free_next = free_reg - 1'b1;
        end

        idx_next = idx_reg;
        if (cmd.idx_clear)
            idx_next = '0;
        else if (cmd.emit_sel == SEL_PAY_HI)
            idx_next = idx_reg + 1'b1;

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg      <= '0;
            free_reg      <= FREE_W'(GROUP_TOKENS);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            desc_reg      <= desc_next;
            free_reg      <= free_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload side, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            case (kind)
                KIND_LIT:
                begin
                    word_reg <= literal_word;
                    bit_reg  <= 1'b0;
                end
                KIND_MATCH:
                begin
                    word_reg <= {8'd0 - distance[7:0], match_length[7:0] + 8'hFF};
                    bit_reg  <= 1'b1;
                end
                default:
                begin
                    // end item: terminator match, payload zero
                    word_reg <= 16'd0;
                    bit_reg  <= 1'b1;
                end
            endcase
        end
        if (cmd.emit_sel == SEL_PAY_HI)
            lo_reg <= rd_reg[7:0];
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= cmd.emit_last;
            out_eos_reg  <= cmd.emit_eos;
        end
    end

    // group payload memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.put)
            mem[slot] <= word_reg;
        rd_reg <= mem[idx_reg[SLOT_W-1:0]];
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last_of_run   = out_last_reg;
    assign end_of_stream = out_eos_reg;

endmodule

### hdl/ltgp_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM: accepts items, sequences token stores and group flushes.
// Depends on ltgp_pkg; commands ltgp_datapath.
module ltgp_ctrl
    import ltgp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  sts_t       sts,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   ending_reg, ending_next;
    logic   final_reg, final_next;
    logic   tail_last;

    // last byte of a flush ends the item unless an end item still owes its terminator
    assign tail_last = final_reg || !ending_reg;

    always_comb
    begin
        state_next  = state_reg;
        ending_next = ending_reg;
        final_next  = final_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (kind == KIND_LIT || kind == KIND_MATCH || kind == KIND_END))
                begin
                    ending_next = (kind == KIND_END);
                    final_next  = 1'b0;
                    state_next  = sts.full ? ST_DESC_HI : ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (ending_reg)
                begin
                    final_next = 1'b1;
                    state_next = ST_DESC_HI;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DESC_HI:
            begin
                if (sts.out_free)
                    state_next = ST_DESC_LO;
            end
            ST_DESC_LO:
            begin
                if (sts.out_free)
                begin
                    if (!sts.group_empty)
                        state_next = ST_PAY_HI;
                    else
                        state_next = final_reg ? ST_IDLE : ST_PUT;
                end
            end
            ST_PAY_HI:
            begin
                if (sts.out_free)
                    state_next = ST_PAY_LO;
            end
            ST_PAY_LO:
            begin
                if (sts.out_free)
                begin
                    if (!sts.pay_done)
                        state_next = ST_PAY_HI;
                    else
                        state_next = final_reg ? ST_IDLE : ST_PUT;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cmd.load_in     = 1'b0;
        cmd.put         = 1'b0;
        cmd.idx_clear   = 1'b0;
        cmd.emit_sel    = SEL_NONE;
        cmd.emit_last   = 1'b0;
        cmd.emit_eos    = 1'b0;
        cmd.clear_group = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_PUT:
                cmd.put = 1'b1;
            ST_DESC_HI:
            begin
                cmd.idx_clear = 1'b1;
                if (sts.out_free)
                    cmd.emit_sel = SEL_DESC_HI;
            end
            ST_DESC_LO:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sel = SEL_DESC_LO;
                    if (sts.group_empty)
                    begin
                        cmd.emit_last   = tail_last;
                        cmd.emit_eos    = final_reg;
                        cmd.clear_group = 1'b1;
                    end
                end
            end
            ST_PAY_HI:
            begin
                if (sts.out_free)
                    cmd.emit_sel = SEL_PAY_HI;
            end
            ST_PAY_LO:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sel = SEL_PAY_LO;
                    if (sts.pay_done)
                    begin
                        cmd.emit_last   = tail_last;
                        cmd.emit_eos    = final_reg;
                        cmd.clear_group = 1'b1;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ending_reg <= 1'b0;
            final_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ending_reg <= ending_next;
            final_reg  <= final_next;
        end
    end

endmodule

### hdl/lzss_token_group_packer.sv
`timescale 1ns / 1ps
// Comper-format packer for LZSS tokens: one input item per token, one output item per byte.
// Input channel in_valid/in_ready carries kind, literal_word, distance, match_length.
// Output channel out_valid/out_ready carries out_byte, last_of_run, end_of_stream.
// Tokens collect into groups of 16; each group goes out as a 2-byte descriptor
// (first token in the top bit) followed by two bytes per token, high byte first.
// A token that fits in the current group produces no bytes; it is accepted, then
// stored. A token that finds the group full first flushes it: 34 bytes at one
// byte per cycle while the receiver takes them. An end item stores a terminator
// match and flushes the partial group: 4 to 38 bytes, 38 if a full group must
// go first. The byte-wide output register sets the flush rate; the next item is
// accepted only once the controller is back in idle.
// last_of_run marks the final byte of an item, end_of_stream the final byte of
// an end item; afterwards the packer is as after reset and a new stream may follow.
// Kind 3 is accepted and dropped. A stalled receiver simply holds the flush.
// Reset (rst_n low, asynchronous) empties the group and drops any pending output.
// Depends on ltgp_pkg, ltgp_ctrl and ltgp_datapath.
module lzss_token_group_packer
    import ltgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] literal_word,
    input  logic [8:0]  distance,
    input  logic [8:0]  match_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        end_of_stream
);

    cmd_t cmd;
    sts_t sts;

    ltgp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    ltgp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .literal_word  (literal_word),
        .distance      (distance),
        .match_length  (match_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .end_of_stream (end_of_stream)
    );

    a_eos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_stream |-> last_of_run)
        else $error("end_of_stream without last_of_run");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_sel != SEL_NONE |-> sts.out_free)
        else $error("byte emitted over an untaken output");

    a_put_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |-> !sts.full)
        else $error("token stored into a full group");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_group |=> sts.group_empty && !sts.full)
        else $error("group not empty after flush");

endmodule

### dv/tb_lzss_token_group_packer.sv
`timescale 1ns / 1ps
// Self-checking testbench for lzss_token_group_packer: directed token streams, then random ones.
// Depends on ltgp_pkg and lzss_token_group_packer; predicts every output byte of the Comper stream.
module tb_lzss_token_group_packer
    import ltgp_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 100;      // longer than one end-item flush
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       eos;
    } stream_byte_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [15:0] literal_word;
    logic [8:0]  distance;
    logic [8:0]  match_length;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        end_of_stream;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;

    // predictor state
    logic [15:0]  group_desc;
    int           group_free;
    logic [15:0]  group_words [GROUP_TOKENS];
    stream_byte_t pending_bytes [$];

    lzss_token_group_packer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .literal_word (literal_word),
        .distance     (distance),
        .match_length (match_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .end_of_stream(end_of_stream)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = KIND_LIT;
        literal_word = '0;
        distance     = '0;
        match_length = '0;
        out_ready    = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ---------------- prediction ----------------

    function automatic void push_stream_byte(input logic [7:0] value);
        stream_byte_t b;
        b.value = value;
        b.last  = 1'b0;
        b.eos   = 1'b0;
        pending_bytes.push_back(b);
    endfunction

    function automatic void flush_group();
        logic [15:0] desc;
        int used;
        used = GROUP_TOKENS - group_free;
        desc = group_desc << group_free;   // left-align a partial group
        push_stream_byte(desc[15:8]);
        push_stream_byte(desc[7:0]);
        for (int i = 0; i < used; i++)
        begin
            push_stream_byte(group_words[i][15:8]);
            push_stream_byte(group_words[i][7:0]);
        end
        group_desc = '0;
        group_free = GROUP_TOKENS;
    endfunction

    function automatic void place_token(input logic flag, input logic [15:0] word);
        if (group_free == 0)
            flush_group();
        group_words[GROUP_TOKENS - group_free] = word;
        group_free--;
        group_desc = {group_desc[14:0], flag};
    endfunction

    function automatic void predict_item(input logic [1:0] k, input logic [15:0] lit,
                                         input logic [8:0] span, input logic [8:0] len);
        int count_at_start;
        logic ending;
        logic [7:0] dist_byte;
        logic [7:0] len_byte;
        stream_byte_t tail;
        count_at_start = pending_bytes.size();
        ending = 1'b0;
        dist_byte = 8'd0 - span[7:0];
        len_byte = len[7:0] - 8'd1;
        case (k)
            KIND_LIT:   place_token(1'b0, lit);
            KIND_MATCH: place_token(1'b1, {dist_byte, len_byte});
            KIND_END:
            begin
                place_token(1'b1, 16'h0000);   // terminator match
                flush_group();
                ending = 1'b1;
            end
            default: ;
        endcase
        if (pending_bytes.size() > count_at_start)
        begin
            tail = pending_bytes.pop_back();
            tail.last = 1'b1;
            tail.eos = ending;
            pending_bytes.push_back(tail);
        end
    endfunction

    // ---------------- output side ----------------

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_bytes
        stream_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected byte %02h last %b eos %b",
                             out_byte, last_of_run, end_of_stream);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.value || last_of_run !== want.last ||
                    end_of_stream !== want.eos)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("byte exp %02h/%b/%b got %02h/%b/%b",
                                 want.value, want.last, want.eos,
                                 out_byte, last_of_run, end_of_stream);
                end
            end
        end
    end

    // ---------------- input side ----------------

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input logic [1:0] k, input logic [15:0] lit,
                             input logic [8:0] span, input logic [8:0] len);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        literal_word <= lit;
        distance     <= span;
        match_length <= len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(k, lit, span, len);
    endtask

    // Sender holds off until the packer has delivered everything.
    task automatic wait_for_drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0 && guard < 200_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [8:0] pick_field9();
        if ($urandom_range(99) < 85)
            return 9'($urandom_range(1, 256));
        return 9'($urandom_range(0, 511));
    endfunction

    task automatic send_random_token();
        if ($urandom_range(1) == 0)
            send_item(KIND_LIT, 16'($urandom), pick_field9(), pick_field9());
        else
            send_item(KIND_MATCH, 16'($urandom), pick_field9(), pick_field9());
    endtask

    // ---------------- tests ----------------

    // Fills exactly one group with field extremes; unused fields carry extremes or noise.
    task automatic test_token_extremes();
        send_item(KIND_LIT, 16'h0000, 9'd511, 9'd511);
        send_item(KIND_LIT, 16'hFFFF, 9'd0, 9'd0);
        send_item(KIND_LIT, 16'h8000, 9'($urandom), 9'($urandom));
        send_item(KIND_LIT, 16'h0001, 9'($urandom), 9'($urandom));
        send_item(KIND_MATCH, 16'hFFFF, 9'd1, 9'd1);
        send_item(KIND_MATCH, 16'h0000, 9'd256, 9'd256);
        send_item(KIND_MATCH, 16'($urandom), 9'd0, 9'd0);       // out of range both ways
        send_item(KIND_MATCH, 16'($urandom), 9'd511, 9'd511);
        send_item(KIND_MATCH, 16'($urandom), 9'd255, 9'd2);
        send_item(KIND_MATCH, 16'($urandom), 9'd128, 9'd257);
        repeat (6) send_random_token();
    endtask

    task automatic test_unused_kind();
        send_item(KIND_UNUSED, 16'($urandom), 9'($urandom), 9'($urandom));
        send_item(KIND_UNUSED, 16'hFFFF, 9'd511, 9'd511);
    endtask

    // Group is full here: end flushes it, then the terminator group.
    task automatic test_end_on_full_group();
        send_item(KIND_END, 16'($urandom), 9'($urandom), 9'($urandom));
    endtask

    task automatic test_end_on_empty_group();
        send_item(KIND_END, 16'hFFFF, 9'd511, 9'd511);
    endtask

    task automatic test_random_streams(input int item_target);
        int sent;
        int tokens;
        sent = 0;
        while (sent < item_target)
        begin
            tokens = ($urandom_range(9) == 0) ? 16 * $urandom_range(1, 2)
                                              : $urandom_range(0, 40);
            for (int i = 0; i < tokens; i++)
            begin
                if ($urandom_range(99) < 4)
                    send_item(KIND_UNUSED, 16'($urandom), 9'($urandom), 9'($urandom));
                send_random_token();
            end
            send_item(KIND_END, 16'($urandom), 9'($urandom), 9'($urandom));
            sent += tokens + 1;
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        group_desc = '0;
        group_free = GROUP_TOKENS;
        send_idle_pct = 12;
        recv_idle_pct = 46;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_token_extremes();
        test_unused_kind();
        test_end_on_full_group();
        test_end_on_empty_group();
        wait_for_drain();

        test_random_streams(55);
        wait_for_drain();

        send_idle_pct = 46;
        recv_idle_pct = 12;
        test_random_streams(55);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_streams(55);
        wait_for_drain();

        if (mismatch_count == 0 && pending_bytes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
